// ===== src/gdr_pkg.sv =====
// ----------------------------------------------------------------------------
// gdr_pkg
// Shared types and codes for the landing-gear operation sequencer.
// ----------------------------------------------------------------------------
package gdr_pkg;

	typedef enum logic [1:0] {
		OPC_TICK    = 2'd0,
		OPC_START   = 2'd1,
		OPC_STOP    = 2'd2,
		OPC_ADVANCE = 2'd3
	} gdr_opcode_t;

	typedef enum logic [1:0] {
		OP_OPEN  = 2'd0,
		OP_MOTOR = 2'd1,
		OP_CLOSE = 2'd2,
		OP_SYNC  = 2'd3
	} gdr_op_t;

	typedef enum logic [1:0] {
		DOOR_CLOSED  = 2'd0,
		DOOR_OPENING = 2'd1,
		DOOR_OPEN    = 2'd2,
		DOOR_CLOSING = 2'd3
	} gdr_door_t;

	localparam logic [2:0] VERDICT_RUNNING   = 3'd0;
	localparam logic [2:0] VERDICT_STALL     = 3'd1;
	localparam logic [2:0] VERDICT_TMO_STALL = 3'd2;
	localparam logic [2:0] VERDICT_NO_MOTOR  = 3'd3;
	localparam logic [2:0] VERDICT_TMO_ERROR = 3'd4;

	localparam logic [2:0] STEP_IDLE       = 3'd0;
	localparam logic [2:0] STEP_OPENING    = 3'd1;
	localparam logic [2:0] STEP_MOTOR      = 3'd2;
	localparam logic [2:0] STEP_CLOSING    = 3'd3;
	localparam logic [2:0] STEP_SYNC_DOORS = 3'd4;
	localparam logic [2:0] STEP_SYNC_MOTOR = 3'd5;

	localparam logic [1:0] REG_OPEN_AT_ONCE      = 2'd0;
	localparam logic [1:0] REG_CLOSE_AT_ONCE_DEP = 2'd1;
	localparam logic [1:0] REG_CLOSE_AT_ONCE_RET = 2'd2;

	localparam int BUILD_STEPS = 5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_BUILD,
		ST_WAIT,
		ST_BEGIN,
		ST_EMIT
	} gdr_state_t;

	typedef struct packed {
		logic latch_in;
		logic advance;
		logic clear_queue;
		logic clear_sync;
		logic start_setup;
		logic build_push;
		logic motor_start;
		logic motor_stop;
		logic ev_open;
		logic ev_close;
		logic ev_stall;
		logic ev_phase;
		logic ev_fin;
		logic ev_err;
		logic load_out;
	} gdr_cmd_t;

	typedef struct packed {
		gdr_opcode_t opcode;
		logic        active;
		gdr_op_t     cur_op;
		logic        door_done;
		logic        door_opening_busy;
		logic        door_open;
		logic        verdict_stop;
		logic        verdict_err;
		logic        open_now;
		logic        close_now;
		logic        build_last;
		logic        out_free;
	} gdr_stat_t;

endpackage

// ===== src/gdr_ctrl.sv =====
// ----------------------------------------------------------------------------
// gdr_ctrl
// Sequencing state machine: dispatches a request, builds the op queue,
// chains through ops that complete at once and hands off the result.
// ----------------------------------------------------------------------------
module gdr_ctrl import gdr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  gdr_stat_t stat,
	output gdr_cmd_t  cmd
);

	gdr_state_t state_q;
	gdr_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				state_nxt = ST_EMIT;
				case (stat.opcode)
					OPC_TICK: begin
						if (stat.active) begin
							if ((stat.cur_op == OP_OPEN || stat.cur_op == OP_CLOSE)
									&& stat.door_done)
								state_nxt = ST_WAIT;
							if (stat.cur_op == OP_MOTOR && stat.verdict_stop)
								state_nxt = ST_WAIT;
						end
					end
					OPC_START: state_nxt = ST_BUILD;
					OPC_STOP: state_nxt = ST_EMIT;
					OPC_ADVANCE: begin
						if (stat.active && stat.cur_op == OP_SYNC) state_nxt = ST_WAIT;
					end
					default: state_nxt = ST_EMIT;
				endcase
			end
			ST_BUILD: begin
				if (stat.build_last) state_nxt = ST_WAIT;
			end
			ST_WAIT: state_nxt = ST_BEGIN;
			ST_BEGIN: begin
				state_nxt = ST_EMIT;
				if (stat.active) begin
					case (stat.cur_op)
						OP_OPEN: begin
							if (!stat.door_opening_busy && (stat.door_open || stat.open_now))
								state_nxt = ST_WAIT;
						end
						OP_CLOSE: begin
							if (stat.close_now) state_nxt = ST_WAIT;
						end
						default: state_nxt = ST_EMIT;
					endcase
				end
			end
			ST_EMIT: begin
				if (stat.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: cmd.latch_in = in_valid;
			ST_DISPATCH: begin
				case (stat.opcode)
					OPC_TICK: begin
						if (stat.active) begin
							case (stat.cur_op)
								OP_OPEN, OP_CLOSE: cmd.advance = stat.door_done;
								OP_MOTOR: begin
									if (stat.verdict_stop) begin
										cmd.motor_stop = 1'b1;
										cmd.advance    = 1'b1;
									end else if (stat.verdict_err) begin
										cmd.clear_queue = 1'b1;
										cmd.ev_phase    = 1'b1;
										cmd.ev_fin      = 1'b1;
										cmd.ev_err      = 1'b1;
									end
								end
								default: cmd.advance = 1'b0;
							endcase
						end
					end
					OPC_START: begin
						cmd.start_setup = 1'b1;
						cmd.clear_queue = 1'b1;
					end
					OPC_STOP: begin
						cmd.clear_queue = 1'b1;
						cmd.clear_sync  = 1'b1;
					end
					OPC_ADVANCE: cmd.advance = stat.active && stat.cur_op == OP_SYNC;
					default: cmd.advance = 1'b0;
				endcase
			end
			ST_BUILD: cmd.build_push = 1'b1;
			ST_BEGIN: begin
				if (!stat.active) begin
					cmd.clear_queue = 1'b1;
					cmd.clear_sync  = 1'b1;
					cmd.ev_phase    = 1'b1;
					cmd.ev_fin      = 1'b1;
				end else begin
					case (stat.cur_op)
						OP_OPEN: begin
							if (stat.door_opening_busy) begin
								cmd.ev_phase = 1'b1;
							end else if (stat.door_open) begin
								cmd.advance = 1'b1;
							end else begin
								cmd.ev_open  = 1'b1;
								cmd.advance  = stat.open_now;
								cmd.ev_phase = !stat.open_now;
							end
						end
						OP_MOTOR: begin
							cmd.motor_start = 1'b1;
							cmd.ev_stall    = 1'b1;
							cmd.ev_phase    = 1'b1;
						end
						OP_CLOSE: begin
							cmd.ev_close = 1'b1;
							cmd.advance  = stat.close_now;
							cmd.ev_phase = !stat.close_now;
						end
						default: cmd.ev_phase = 1'b1;
					endcase
				end
			end
			ST_EMIT: cmd.load_out = stat.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

// ===== src/gdr_dpath.sv =====
// ----------------------------------------------------------------------------
// gdr_dpath
// Datapath: request registers, op queue memory, queue pointers, flags,
// config registers and the result register.
// ----------------------------------------------------------------------------
module gdr_dpath import gdr_pkg::*; #(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  gdr_cmd_t          cmd,
	output gdr_stat_t         stat,
	input  logic [1:0]        opcode,
	input  logic              deploy_dir,
	input  logic              sync_wanted,
	input  logic              door_busy,
	input  logic [1:0]        door_status,
	input  logic              door_done,
	input  logic [2:0]        stall_verdict,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic              cfg_data,
	output logic              out_valid,
	input  logic              out_stall,
	output logic signed [1:0] motor_drive,
	output logic              motor_on,
	output logic              door_open_cmd,
	output logic              door_close_cmd,
	output logic              door_cmd_deploy,
	output logic              stall_start,
	output logic [2:0]        step_code,
	output logic              phase_event,
	output logic              seq_finished,
	output logic              seq_error,
	output logic              dir_deploying
);

	localparam int IDX_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W = $clog2(QUEUE_DEPTH);

	gdr_opcode_t opcode_q;
	logic        dep_in_q;
	logic        syn_in_q;
	logic        busy_q;
	gdr_door_t   door_q;
	logic        done_q;
	logic [2:0]  verdict_q;

	logic cfg_open_q;
	logic cfg_close_dep_q;
	logic cfg_close_ret_q;

	gdr_op_t    mem_q [QUEUE_DEPTH];
	gdr_op_t    rd_q;
	logic [IDX_W-1:0] count_q;
	logic [IDX_W-1:0] idx_q;
	logic [2:0] build_k_q;
	logic       need_open_q;
	logic       prev_motor_q;

	logic dep_q;
	logic sync_q;
	logic motor_q;

	logic ev_open_q, ev_close_q, ev_cmd_dep_q, ev_stall_q;
	logic ev_phase_q, ev_fin_q, ev_err_q;
	logic out_valid_q;

	logic    active;
	logic    need_open;
	logic    build_inc;
	gdr_op_t build_op;
	logic [2:0] step_now;

	assign active = (idx_q < count_q);

	always_comb begin
		need_open = 1'b1;
		if (active) begin
			case (rd_q)
				OP_OPEN:  need_open = syn_in_q;
				OP_MOTOR: need_open = 1'b0;
				OP_CLOSE: need_open = 1'b1;
				default:  need_open = 1'b0;
			endcase
		end
	end

	always_comb begin
		case (build_k_q)
			3'd0: begin
				build_inc = need_open_q;
				build_op  = OP_OPEN;
			end
			3'd1, 3'd3: begin
				build_inc = sync_q;
				build_op  = OP_SYNC;
			end
			3'd2: begin
				build_inc = 1'b1;
				build_op  = OP_MOTOR;
			end
			default: begin
				build_inc = 1'b1;
				build_op  = OP_CLOSE;
			end
		endcase
	end

	always_comb begin
		step_now = STEP_IDLE;
		if (active) begin
			case (rd_q)
				OP_OPEN:  step_now = STEP_OPENING;
				OP_MOTOR: step_now = STEP_MOTOR;
				OP_CLOSE: step_now = STEP_CLOSING;
				default:  step_now = prev_motor_q ? STEP_SYNC_MOTOR : STEP_SYNC_DOORS;
			endcase
		end
	end

	always_comb begin
		stat.opcode            = opcode_q;
		stat.active            = active;
		stat.cur_op            = rd_q;
		stat.door_done         = done_q;
		stat.door_opening_busy = busy_q && door_q == DOOR_OPENING;
		stat.door_open         = (door_q == DOOR_OPEN);
		stat.verdict_stop      = (verdict_q == VERDICT_STALL || verdict_q == VERDICT_TMO_STALL
			|| verdict_q == VERDICT_NO_MOTOR);
		stat.verdict_err       = (verdict_q == VERDICT_TMO_ERROR);
		stat.open_now          = cfg_open_q;
		stat.close_now         = dep_q ? cfg_close_dep_q : cfg_close_ret_q;
		stat.build_last        = (build_k_q == 3'(BUILD_STEPS - 1));
		stat.out_free          = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			opcode_q  <= gdr_opcode_t'(opcode);
			dep_in_q  <= deploy_dir;
			syn_in_q  <= sync_wanted;
			busy_q    <= door_busy;
			door_q    <= gdr_door_t'(door_status);
			done_q    <= door_done;
			verdict_q <= stall_verdict;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.build_push && build_inc && count_q < IDX_W'(QUEUE_DEPTH))
			mem_q[count_q[ADDR_W-1:0]] <= build_op;
		if (idx_q < IDX_W'(QUEUE_DEPTH))
			rd_q <= mem_q[idx_q[ADDR_W-1:0]];
		else
			rd_q <= OP_OPEN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_open_q      <= 1'b0;
			cfg_close_dep_q <= 1'b0;
			cfg_close_ret_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OPEN_AT_ONCE:      cfg_open_q      <= cfg_data;
				REG_CLOSE_AT_ONCE_DEP: cfg_close_dep_q <= cfg_data;
				REG_CLOSE_AT_ONCE_RET: cfg_close_ret_q <= cfg_data;
				default:               cfg_open_q      <= cfg_open_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			idx_q        <= '0;
			build_k_q    <= '0;
			need_open_q  <= 1'b0;
			prev_motor_q <= 1'b0;
			dep_q        <= 1'b0;
			sync_q       <= 1'b0;
			motor_q      <= 1'b0;
		end else begin
			if (cmd.start_setup) begin
				need_open_q <= need_open;
				dep_q       <= dep_in_q;
				sync_q      <= syn_in_q;
				build_k_q   <= '0;
			end
			if (cmd.clear_queue) begin
				count_q      <= '0;
				idx_q        <= '0;
				prev_motor_q <= 1'b0;
				motor_q      <= 1'b0;
			end
			if (cmd.clear_sync) sync_q <= 1'b0;
			if (cmd.build_push) begin
				build_k_q <= build_k_q + 3'd1;
				if (build_inc && count_q < IDX_W'(QUEUE_DEPTH)) count_q <= count_q + 1'b1;
			end
			if (cmd.advance && active) begin
				idx_q        <= idx_q + 1'b1;
				prev_motor_q <= (rd_q == OP_MOTOR);
			end
			if (cmd.motor_start) motor_q <= 1'b1;
			if (cmd.motor_stop)  motor_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_open_q    <= 1'b0;
			ev_close_q   <= 1'b0;
			ev_cmd_dep_q <= 1'b0;
			ev_stall_q   <= 1'b0;
			ev_phase_q   <= 1'b0;
			ev_fin_q     <= 1'b0;
			ev_err_q     <= 1'b0;
		end else if (cmd.latch_in) begin
			ev_open_q    <= 1'b0;
			ev_close_q   <= 1'b0;
			ev_cmd_dep_q <= 1'b0;
			ev_stall_q   <= 1'b0;
			ev_phase_q   <= 1'b0;
			ev_fin_q     <= 1'b0;
			ev_err_q     <= 1'b0;
		end else begin
			if (cmd.ev_open) begin
				ev_open_q    <= 1'b1;
				ev_cmd_dep_q <= 1'b1;
			end
			if (cmd.ev_close) begin
				ev_close_q   <= 1'b1;
				ev_cmd_dep_q <= dep_q;
			end
			if (cmd.ev_stall) ev_stall_q <= 1'b1;
			if (cmd.ev_phase) ev_phase_q <= 1'b1;
			if (cmd.ev_fin)   ev_fin_q   <= 1'b1;
			if (cmd.ev_err)   ev_err_q   <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			motor_drive     <= motor_q ? (dep_q ? 2'sd1 : -2'sd1) : 2'sd0;
			motor_on        <= motor_q;
			door_open_cmd   <= ev_open_q;
			door_close_cmd  <= ev_close_q;
			door_cmd_deploy <= (ev_open_q || ev_close_q) && ev_cmd_dep_q;
			stall_start     <= ev_stall_q;
			step_code       <= step_now;
			phase_event     <= ev_phase_q;
			seq_finished    <= ev_fin_q;
			seq_error       <= ev_err_q;
			dir_deploying   <= dep_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== src/gear_deploy_retract_op_sequencer.sv =====
// ----------------------------------------------------------------------------
// gear_deploy_retract_op_sequencer
// Landing-gear deploy/retract op sequencer: queue of door, sync and motor ops.
//
//   channel | handshake             | content
//   --------+-----------------------+-------------------------------------------
//   in      | in_valid / in_stall   | opcode, direction, door and stall status
//   out     | out_valid / out_stall | motor drive, door commands, step, flags
//   cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data (one bit register)
//
// One request at a time. Tick, stop and advance go from accept through dispatch
// to the result register; each op that completes at once adds a pass through wait and begin.
// Start also builds the queue before that: the queue is written one entry
// a cycle and the queue memory has one registered read port.
// A waiting result stalls the next request only at its own hand-off.
// Reset clears all control state and the config registers; no clearing pass.
// ----------------------------------------------------------------------------
module gear_deploy_retract_op_sequencer import gdr_pkg::*; #(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        opcode,
	input  logic              deploy_dir,
	input  logic              sync_wanted,
	input  logic              door_busy,
	input  logic [1:0]        door_status,
	input  logic              door_done,
	input  logic [2:0]        stall_verdict,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic              cfg_data,
	output logic              out_valid,
	input  logic              out_stall,
	output logic signed [1:0] motor_drive,
	output logic              motor_on,
	output logic              door_open_cmd,
	output logic              door_close_cmd,
	output logic              door_cmd_deploy,
	output logic              stall_start,
	output logic [2:0]        step_code,
	output logic              phase_event,
	output logic              seq_finished,
	output logic              seq_error,
	output logic              dir_deploying
);

	gdr_cmd_t  cmd;
	gdr_stat_t stat;

	assign cfg_ready = 1'b1;

	gdr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	gdr_dpath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.opcode          (opcode),
		.deploy_dir      (deploy_dir),
		.sync_wanted     (sync_wanted),
		.door_busy       (door_busy),
		.door_status     (door_status),
		.door_done       (door_done),
		.stall_verdict   (stall_verdict),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.motor_drive     (motor_drive),
		.motor_on        (motor_on),
		.door_open_cmd   (door_open_cmd),
		.door_close_cmd  (door_close_cmd),
		.door_cmd_deploy (door_cmd_deploy),
		.stall_start     (stall_start),
		.step_code       (step_code),
		.phase_event     (phase_event),
		.seq_finished    (seq_finished),
		.seq_error       (seq_error),
		.dir_deploying   (dir_deploying)
	);

endmodule

// ===== src/gdr_checker.sv =====
// ----------------------------------------------------------------------------
// gdr_checker
// Port-level checks for the op sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module gdr_checker import gdr_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic signed [1:0] motor_drive,
	input logic              motor_on,
	input logic              door_open_cmd,
	input logic              door_close_cmd,
	input logic              door_cmd_deploy,
	input logic [2:0]        step_code,
	input logic              phase_event,
	input logic              seq_finished,
	input logic              seq_error
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(step_code) && $stable(motor_drive))
		else $error("result changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while previous one in work");

	a_error_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seq_error |-> seq_finished && phase_event)
		else $error("error result without finish");

	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seq_finished |-> step_code == STEP_IDLE && !motor_on)
		else $error("finished sequence left active");

	a_drive_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (motor_on == (motor_drive != 2'sd0))
			&& (!door_cmd_deploy || door_open_cmd || door_close_cmd))
		else $error("motor or door command flags inconsistent");

endmodule

bind gear_deploy_retract_op_sequencer gdr_checker u_gdr_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.motor_drive     (motor_drive),
	.motor_on        (motor_on),
	.door_open_cmd   (door_open_cmd),
	.door_close_cmd  (door_close_cmd),
	.door_cmd_deploy (door_cmd_deploy),
	.step_code       (step_code),
	.phase_event     (phase_event),
	.seq_finished    (seq_finished),
	.seq_error       (seq_error)
);
